// File: sv/sobel_5x5_rgb_edge_magnitude_assert.svh
// Assertion macros shared by the RTL.
`ifndef SOBEL_5X5_RGB_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_5X5_RGB_EDGE_MAGNITUDE_ASSERT_SVH

`ifndef SYNTH
`define S5E_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("s5e assertion failed");
`define S5E_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("s5e assertion failed");
`else
`define S5E_ASSERT_IMP(lbl, a, b)
`define S5E_ASSERT_NXT(lbl, a, b)
`endif

`endif

// File: sv/s5e_pkg.sv
package s5e_pkg;

  localparam int MAX_W     = 2048;
  localparam int MAX_H     = 2048;
  localparam int COL_W     = 11;
  localparam int SLOT_W    = 3;
  localparam int RAM_DEPTH = 8 * MAX_W;
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int PIX_W     = 24;
  localparam int ACC_W     = 17;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // input word kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  // [column tap][row tap]
  localparam logic signed [4:0] KX [0:4][0:4] = '{
    '{-5'sd1, -5'sd4, -5'sd6, -5'sd4, -5'sd1},
    '{-5'sd2, -5'sd8, -5'sd12, -5'sd8, -5'sd2},
    '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
    '{5'sd2, 5'sd8, 5'sd12, 5'sd8, 5'sd2},
    '{5'sd1, 5'sd4, 5'sd6, 5'sd4, 5'sd1}};
  localparam logic signed [4:0] KY [0:4][0:4] = '{
    '{-5'sd1, -5'sd2, 5'sd0, 5'sd2, 5'sd1},
    '{-5'sd4, -5'sd8, 5'sd0, 5'sd8, 5'sd4},
    '{-5'sd6, -5'sd12, 5'sd0, 5'sd12, 5'sd6},
    '{-5'sd4, -5'sd8, 5'sd0, 5'sd8, 5'sd4},
    '{-5'sd1, -5'sd2, 5'sd0, 5'sd2, 5'sd1}};

  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t tap_term(input logic [7:0] s, input logic signed [4:0] k);
    logic signed [13:0] p;
    p = $signed({1'b0, s}) * k;
    return ACC_W'(p);
  endfunction

endpackage

// File: sv/s5e_ram.sv
module s5e_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/s5e_mag.sv
module s5e_mag
  import s5e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  acc_t       gx [3],
  input  acc_t       gy [3],
  output logic       done,
  output logic [7:0] mag [3]
);

  typedef enum logic [1:0] {M_IDLE, M_SUM, M_ITER} mphase_t;

  mphase_t     phase_r;
  logic [3:0]  cnt_r;
  logic [33:0] sqa_r [3];
  logic [33:0] sqb_r [3];
  logic [31:0] x_r   [3];
  logic [31:0] res_r [3];
  logic [31:0] bit_r;
  logic        done_r;
  logic [7:0]  mag_r [3];

  // Square root one result bit per cycle, three lanes side by side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        M_IDLE: begin
          if (start) begin
            phase_r <= M_SUM;
          end
        end
        M_SUM: begin
          phase_r <= M_ITER;
          cnt_r   <= '0;
        end
        M_ITER: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            phase_r <= M_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start && phase_r == M_IDLE) begin
        sqa_r[i] <= 34'(gx[i] * gx[i]);
        sqb_r[i] <= 34'(gy[i] * gy[i]);
      end
      if (phase_r == M_SUM) begin
        x_r[i]   <= 32'(sqa_r[i] + sqb_r[i]);
        res_r[i] <= '0;
      end else if (phase_r == M_ITER) begin
        if (x_r[i] >= res_r[i] + bit_r) begin
          x_r[i]   <= x_r[i] - (res_r[i] + bit_r);
          res_r[i] <= (res_r[i] >> 1) + bit_r;
        end else begin
          res_r[i] <= res_r[i] >> 1;
        end
      end
      if (done_r) begin
        mag_r[i] <= (res_r[i][31:3] > 29'd255) ? 8'd255 : res_r[i][10:3];
      end
    end
    if (phase_r == M_SUM) begin
      bit_r <= 32'h4000_0000;
    end else if (phase_r == M_ITER) begin
      bit_r <= bit_r >> 2;
    end
  end

  // done is a registered copy of the internal done flag and rises with mag settled
  logic done_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_d_r <= 1'b0;
    end else begin
      done_d_r <= done_r;
    end
  end

  assign done = done_d_r;
  assign mag  = mag_r;

endmodule

// File: sv/sobel_5x5_rgb_edge_magnitude.sv
// Order: an output word leaves 2*W+2 input words after its pixel. A word that gives
// a result holds in_tready low through 25 line-store reads, the read latency, squares,
// a 16-step bit-serial square root and an output load that waits for a free output
// register; a word with no result leaves the block idle. The line store has one read port.
// Reset (rst_n low, synchronous): counters cleared, width 640, height 480; the line
// store is not cleared and needs no clearing pass.
module sobel_5x5_rgb_edge_magnitude
  import s5e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_red, in_green, in_blue
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_col, out_row, out_red, out_green, out_blue
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

`include "sobel_5x5_rgb_edge_magnitude_assert.svh"

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_LAST, ST_SQ, ST_MAG, ST_OUT} state_t;

  state_t state_r;

  // configuration
  logic [11:0] wcfg_r, hcfg_r, w_eff, h_eff;
  logic [12:0] lag;

  assign w_eff = (wcfg_r == 12'd0) ? 12'd1 : (wcfg_r > 12'(MAX_W)) ? 12'(MAX_W) : wcfg_r;
  assign h_eff = (hcfg_r == 12'd0) ? 12'd1 : (hcfg_r > 12'(MAX_H)) ? 12'(MAX_H) : hcfg_r;
  assign lag   = {w_eff, 1'b0} + 13'd2;
  assign cfg_ready = 1'b1;

  // position counters: writer side and output side
  logic [COL_W-1:0]  in_col_r, ocol_r, cc_r;
  logic [11:0]       in_row_r;
  logic [COL_W-1:0]  orow_r, cr_r;
  logic [SLOT_W-1:0] in_slot_r, oslot_r, cslot_r;
  logic [12:0]       lag_cnt_r;
  logic              fe_r;

  logic accept, pix_phase, ignore, emit, fe_now, cfg_wr;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign pix_phase = in_row_r < h_eff;
  assign ignore    = pix_phase && (in_tuser == OP_PAD);
  assign emit      = (lag_cnt_r >= lag);
  assign fe_now    = ({1'b0, orow_r} == h_eff - 12'd1) && ({1'b0, ocol_r} == w_eff - 12'd1);
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // window tap walk
  logic [2:0] tu_r, tv_r, tu_d_r, tv_d_r;
  logic       tap_vld_r, tap_ok_r;
  logic [12:0] yy, xx;
  logic [SLOT_W-1:0] rslot;
  logic        tap_ok;

  assign yy = {2'b0, cr_r} + {10'b0, tv_r};
  assign xx = {2'b0, cc_r} + {10'b0, tu_r};
  assign tap_ok = (yy >= 13'd2) && (yy - 13'd2 < {1'b0, h_eff}) &&
                  (xx >= 13'd2) && (xx - 13'd2 < {1'b0, w_eff});
  // row offset tv-2, wraps over the eight slots
  assign rslot = cslot_r + tv_r + 3'd6;

  // line store: eight rows, slot = row mod 8; the writer runs 2*W+2 words ahead of the
  // window centre, so it never overwrites a row that the window still reads
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic [COL_W-1:0]  rcol;

  assign ram_we    = accept && pix_phase && !ignore;
  assign ram_waddr = {in_slot_r, in_col_r};
  assign ram_wdata = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
  assign rcol      = COL_W'(xx - 13'd2);
  assign ram_re    = (state_r == ST_READ) && tap_ok;
  assign ram_raddr = {rslot, rcol};

  s5e_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // gradient accumulators
  acc_t gx_r [3];
  acc_t gy_r [3];
  logic [7:0] smp [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      smp[ch] = tap_ok_r ? ram_rdata[16 - 8*ch +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (accept) begin
        gx_r[ch] <= '0;
        gy_r[ch] <= '0;
      end else if (tap_vld_r) begin
        gx_r[ch] <= gx_r[ch] + tap_term(smp[ch], KX[tu_d_r][tv_d_r]);
        gy_r[ch] <= gy_r[ch] + tap_term(smp[ch], KY[tu_d_r][tv_d_r]);
      end
    end
  end

  // magnitude unit
  logic       mag_done;
  logic [7:0] mag [3];

  s5e_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQ),
    .gx    (gx_r),
    .gy    (gy_r),
    .done  (mag_done),
    .mag   (mag)
  );

  // output register
  logic        out_vld_r, out_last_r;
  logic [47:0] out_data_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wcfg_r    <= 12'd640;
      hcfg_r    <= 12'd480;
      in_col_r  <= '0;
      in_row_r  <= '0;
      in_slot_r <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      oslot_r   <= '0;
      lag_cnt_r <= '0;
      tap_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      tap_vld_r <= (state_r == ST_READ);
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr) begin
        if (cfg_index == REG_WIDTH) begin
          wcfg_r <= cfg_data;
        end else begin
          hcfg_r <= cfg_data;
        end
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_slot_r <= '0;
        ocol_r    <= '0;
        orow_r    <= '0;
        oslot_r   <= '0;
        lag_cnt_r <= '0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && !ignore) begin
            if (emit && fe_now) begin
              // frame fully drained: start over
              in_col_r  <= '0;
              in_row_r  <= '0;
              in_slot_r <= '0;
              ocol_r    <= '0;
              orow_r    <= '0;
              oslot_r   <= '0;
              lag_cnt_r <= '0;
            end else begin
              if ({1'b0, in_col_r} + 12'd1 >= w_eff) begin
                in_col_r  <= '0;
                in_row_r  <= in_row_r + 12'd1;
                in_slot_r <= in_slot_r + 3'd1;
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
              if (!emit) begin
                lag_cnt_r <= lag_cnt_r + 13'd1;
              end else if ({1'b0, ocol_r} + 12'd1 >= w_eff) begin
                ocol_r  <= '0;
                orow_r  <= orow_r + 1'b1;
                oslot_r <= oslot_r + 3'd1;
              end else begin
                ocol_r <= ocol_r + 1'b1;
              end
            end
            if (emit) begin
              cr_r    <= orow_r;
              cc_r    <= ocol_r;
              cslot_r <= oslot_r;
              fe_r    <= fe_now;
              tu_r    <= '0;
              tv_r    <= '0;
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          tu_d_r   <= tu_r;
          tv_d_r   <= tv_r;
          tap_ok_r <= tap_ok;
          if (tu_r == 3'd4) begin
            tu_r <= '0;
            tv_r <= tv_r + 3'd1;
            if (tv_r == 3'd4) begin
              state_r <= ST_LAST;
            end
          end else begin
            tu_r <= tu_r + 3'd1;
          end
        end
        ST_LAST: state_r <= ST_SQ;
        ST_SQ:   state_r <= ST_MAG;
        ST_MAG: begin
          if (mag_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r  <= 1'b1;
            out_last_r <= fe_r;
            out_data_r <= {2'b0, cc_r, cr_r, mag[2], mag[1], mag[0]};
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `S5E_ASSERT_IMP(a_mag_in_wait, mag_done, state_r == ST_MAG)
  `S5E_ASSERT_IMP(a_tap_window, tap_vld_r, state_r == ST_READ || state_r == ST_LAST)
  `S5E_ASSERT_NXT(a_frame_restart, accept && !ignore && emit && fe_now && !cfg_wr,
                  lag_cnt_r == 13'd0 && in_row_r == 12'd0)

endmodule
